// File: rtl/kqt_pkg.sv
// ---------------------------------------------------------------------------
// kqt_pkg: shared types for the keyed quantity table
// Request and response payloads, status and mode codes, the search token
// that runs down the cell chain and the write command sent back to a cell.
// ---------------------------------------------------------------------------
package kqt_pkg;

  localparam int ENTRIES    = 16;
  localparam int KEY_BITS   = 16;
  localparam int COUNT_BITS = 31;
  localparam int IDX_BITS   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  typedef logic [KEY_BITS-1:0]   key_t;
  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [IDX_BITS-1:0]   idx_t;

  localparam count_t COUNT_MAX = {COUNT_BITS{1'b1}};

  typedef enum logic [1:0] {
    MODE_ADD    = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_QUERY  = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_INVALID = 2'd1,
    STATUS_MISSING = 2'd2,
    STATUS_FULL    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WAIT
  } state_e;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] item_key;
    logic [15:0] quantity;
  } req_t;

  typedef struct packed {
    status_e status;
    count_t  count;
    logic    enough;
  } rsp_t;

  // search token: carries the key and what the cells seen so far reported
  typedef struct packed {
    logic   valid;
    key_t   key;
    logic   hit;
    idx_t   hit_idx;
    count_t hit_count;
    logic   free;
    idx_t   free_idx;
  } scan_tok_t;

  // entry update addressed to one cell
  typedef struct packed {
    logic   en;
    idx_t   idx;
    logic   valid;
    key_t   key;
    count_t count;
  } cell_wr_t;

  // take the low KEY_BITS bits of the 16-bit key field, zero-extended
  function automatic key_t key_of(logic [15:0] field);
    logic [31:0] wide;
    key_t        k;
    wide = {16'b0, field};
    for (int i = 0; i < KEY_BITS; i++) begin
      k[i] = wide[i];
    end
    return k;
  endfunction

endpackage

// File: rtl/kqt_cell.sv
// ---------------------------------------------------------------------------
// kqt_cell: one table entry of the keyed quantity table
// Holds a key, a count and a valid bit, annotates the passing search token
// with a key hit or a free slot, and takes entry updates addressed to it.
// ---------------------------------------------------------------------------
module kqt_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  kqt_pkg::idx_t      cell_idx_i,
  input  kqt_pkg::scan_tok_t tok_i,
  output kqt_pkg::scan_tok_t tok_o,
  input  kqt_pkg::cell_wr_t  wr_i
);

  logic               valid_q;
  kqt_pkg::key_t      key_q;
  kqt_pkg::count_t    count_q;
  kqt_pkg::scan_tok_t tok_d, tok_q;

  // mark the first hit and the first free slot along the chain
  always_comb begin
    tok_d = tok_i;
    if (tok_i.valid) begin
      if (valid_q && (key_q == tok_i.key) && !tok_i.hit) begin
        tok_d.hit       = 1'b1;
        tok_d.hit_idx   = cell_idx_i;
        tok_d.hit_count = count_q;
      end
      if (!valid_q && !tok_i.free) begin
        tok_d.free     = 1'b1;
        tok_d.free_idx = cell_idx_i;
      end
    end
  end

  // advance the token to the next cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

  // entry valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (wr_i.en && (wr_i.idx == cell_idx_i)) begin
      valid_q <= wr_i.valid;
    end
  end

  // entry payload
  always_ff @(posedge clk_i) begin
    if (wr_i.en && (wr_i.idx == cell_idx_i)) begin
      key_q   <= wr_i.key;
      count_q <= wr_i.count;
    end
  end

endmodule

// File: rtl/keyed_quantity_table_unit.sv
// ---------------------------------------------------------------------------
// keyed_quantity_table_unit: counting associative table of key/count pairs
// Requests (mode, item_key, quantity) enter on the in channel; one response
// (status, count, enough) per request leaves on the out channel.
//
// A request is taken while in_stall_o is low; in_stall_o then stays high
// until the response of that request has been loaded into the output
// register. The scan runs a search token down a chain of ENTRIES cells,
// one cell per cycle. When the token leaves the chain, the entry update is
// applied and the response is captured; the response is then loaded into
// the output register once that register is free. A new request is taken
// only after the response of the previous one has been loaded.
//
// The output register holds a response while out_stall_i is high; a new
// request may be taken meanwhile, and its response waits until the output
// register is free.
// Reset clears all entry valid bits, the chain tokens and the output valid;
// the table is empty and ready on the first cycle after reset.
// ---------------------------------------------------------------------------
module keyed_quantity_table_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  kqt_pkg::req_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output kqt_pkg::rsp_t out_data_o
);

  kqt_pkg::state_e    state_q, state_d;
  kqt_pkg::req_t      req_q;
  kqt_pkg::rsp_t      res_q, res_d;
  kqt_pkg::rsp_t      out_q;
  logic               out_valid_q;
  kqt_pkg::cell_wr_t  wr;
  kqt_pkg::scan_tok_t head_tok;
  kqt_pkg::scan_tok_t tok [kqt_pkg::ENTRIES+1];
  logic [kqt_pkg::ENTRIES-1:0] tok_vld;
  logic               in_accept;
  logic               scan_done;
  logic               out_free;

  assign in_stall_o = (state_q != kqt_pkg::ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign scan_done  = (state_q == kqt_pkg::ST_SCAN) && tok[kqt_pkg::ENTRIES].valid;
  assign out_free   = !out_valid_q || !out_stall_i;

  // launch a fresh token into the head of the chain
  always_comb begin
    head_tok       = '0;
    head_tok.valid = in_accept;
    head_tok.key   = kqt_pkg::key_of(in_data_i.item_key);
  end

  assign tok[0] = head_tok;

  // cell chain
  for (genvar i = 0; i < kqt_pkg::ENTRIES; i++) begin : g_cell
    kqt_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (kqt_pkg::idx_t'(i)),
      .tok_i      (tok[i]),
      .tok_o      (tok[i+1]),
      .wr_i       (wr)
    );
    assign tok_vld[i] = tok[i+1].valid;
  end

  // hold the request during the scan
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      req_q <= in_data_i;
    end
  end

  // decide the response and the entry update from the finished token
  always_comb begin
    kqt_pkg::scan_tok_t       t;
    kqt_pkg::key_t            key;
    logic [15:0]              qty;
    kqt_pkg::count_t          cnt;
    kqt_pkg::count_t          qty_w;
    logic [kqt_pkg::COUNT_BITS:0] sum;
    kqt_pkg::count_t          diff;
    t     = tok[kqt_pkg::ENTRIES];
    key   = kqt_pkg::key_of(req_q.item_key);
    qty   = req_q.quantity;
    qty_w = kqt_pkg::count_t'(qty);
    cnt   = t.hit ? t.hit_count : '0;
    sum   = {1'b0, cnt} + (kqt_pkg::COUNT_BITS+1)'(qty);
    diff  = cnt - qty_w;
    res_d        = '0;
    res_d.status = kqt_pkg::STATUS_OK;
    wr           = '0;
    wr.key       = key;
    if (key == '0) begin
      res_d.status = kqt_pkg::STATUS_INVALID;
      cnt          = '0;
    end else begin
      case (req_q.mode)
        kqt_pkg::MODE_ADD: begin
          if (qty == '0) begin
            res_d.status = kqt_pkg::STATUS_INVALID;
          end else if (t.hit) begin
            cnt      = sum[kqt_pkg::COUNT_BITS] ? kqt_pkg::COUNT_MAX
                                                : sum[kqt_pkg::COUNT_BITS-1:0];
            wr.en    = scan_done;
            wr.idx   = t.hit_idx;
            wr.valid = 1'b1;
            wr.count = cnt;
          end else if (t.free) begin
            cnt      = qty_w;
            wr.en    = scan_done;
            wr.idx   = t.free_idx;
            wr.valid = 1'b1;
            wr.count = cnt;
          end else begin
            res_d.status = kqt_pkg::STATUS_FULL;
          end
        end
        kqt_pkg::MODE_REMOVE: begin
          if (qty == '0) begin
            res_d.status = kqt_pkg::STATUS_INVALID;
          end else if (!t.hit || (cnt < qty_w)) begin
            res_d.status = kqt_pkg::STATUS_MISSING;
          end else begin
            cnt      = diff;
            wr.en    = scan_done;
            wr.idx   = t.hit_idx;
            wr.valid = (diff != '0);
            wr.count = diff;
          end
        end
        default: begin
          // query, and the unused code, leave the table alone
        end
      endcase
    end
    res_d.count  = cnt;
    res_d.enough = (cnt >= qty_w);
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= kqt_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      kqt_pkg::ST_IDLE: begin
        if (in_accept) state_d = kqt_pkg::ST_SCAN;
      end
      kqt_pkg::ST_SCAN: begin
        if (scan_done) state_d = kqt_pkg::ST_WAIT;
      end
      kqt_pkg::ST_WAIT: begin
        if (out_free) state_d = kqt_pkg::ST_IDLE;
      end
      default: state_d = kqt_pkg::ST_IDLE;
    endcase
  end

  // capture the response at the end of the scan
  always_ff @(posedge clk_i) begin
    if (scan_done) begin
      res_q <= res_d;
    end
  end

  // output register: load when free, drop on transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == kqt_pkg::ST_WAIT) && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == kqt_pkg::ST_WAIT) && out_free) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // checks
  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(tok_vld) <= 1)
    else $error("more than one search token in the chain");

  a_token_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok[kqt_pkg::ENTRIES].valid |-> (state_q == kqt_pkg::ST_SCAN))
    else $error("token left the chain outside a scan");

  a_write_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr.en |-> scan_done)
    else $error("entry update outside the end of a scan");

  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (in_stall_o && (state_q == kqt_pkg::ST_SCAN)))
    else $error("request taken without starting a scan");

endmodule
